// ----- rtl/modular_exponentiation_assert.svh -----
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication
`define MODEXP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modexp check failed");

// next-cycle implication
`define MODEXP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modexp check failed");

`endif

// ----- rtl/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// modexp package
// widths and shared types of the modular exponentiation block
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int OP_W       = 32;
   localparam int CNT_W      = $clog2(OP_W);
   localparam int REQ_DATA_W = 2 * OP_W;
   localparam int RSP_DATA_W = OP_W;

   typedef logic [OP_W-1:0]  operand_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic        start;
      operand_type x;
      operand_type y;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      operand_type product;
   } mul_rsp_type;

endpackage

// ----- rtl/modexp_mul.sv -----
// ----------------------------------------------------------------------------
// modexp bit-serial modular multiplier
// interleaved multiply and reduce, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module modexp_mul (
   input  logic                    clock,
   input  logic                    reset,
   input  modexp_pkg::operand_type modulus,
   input  modexp_pkg::mul_req_type mul_req,
   output modexp_pkg::mul_rsp_type mul_rsp
);
   import modexp_pkg::*;

   localparam int EXT_W = OP_W + 3;

   operand_type x_ff, x_in;
   operand_type y_ff, y_in;
   operand_type r_ff, r_in;
   count_type   cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [EXT_W-1:0] sum;
   logic [EXT_W-1:0] less_one;
   logic [EXT_W-1:0] less_two;
   operand_type      addend;

   // r < m and y < m keep the sum below three times the modulus
   always_comb begin
      addend   = x_ff[OP_W-1] ? y_ff : '0;
      sum      = {2'b00, r_ff, 1'b0} + {3'b000, addend};
      less_one = sum - {3'b000, modulus};
      less_two = sum - {2'b00, modulus, 1'b0};
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         x_in   = {x_ff[OP_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (!less_two[EXT_W-1]) begin
            r_in = less_two[OP_W-1:0];
         end else if (!less_one[EXT_W-1]) begin
            r_in = less_one[OP_W-1:0];
         end else begin
            r_in = sum[OP_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (mul_req.start) begin
         x_in    = mul_req.x;
         y_in    = mul_req.y;
         r_in    = '0;
         cnt_in  = CNT_W'(OP_W - 1);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = r_ff;

endmodule

// ----- rtl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular exponentiation
// base to the exponent modulo a configured modulus, square and multiply
// ----------------------------------------------------------------------------
// One request at a time. The base is first reduced by one pass of the
// bit-serial modular multiplier, then each of the 32 exponent bits, from the
// lsb up, takes a squaring and, when the bit is set, a multiply into the
// accumulator, each a full pass of the multiplier. A zero modulus skips the
// multiplier and returns residue 0 with the error flag in rsp_tuser. A new
// request is taken while the previous response still waits in the output
// register.
// ----------------------------------------------------------------------------
module modular_exponentiation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [modexp_pkg::OP_W-1:0]           csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] base_value, [63:32] exponent
   input  logic [modexp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] residue
   output logic [modexp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] modulus_error
   output logic                                  rsp_tuser
);
   import modexp_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_REDUCE  = 3'd1;
   localparam logic [2:0] ST_STEP    = 3'd2;
   localparam logic [2:0] ST_MUL_ACC = 3'd3;
   localparam logic [2:0] ST_MUL_SQ  = 3'd4;
   localparam logic [2:0] ST_FINISH  = 3'd5;

   logic [2:0]  state_ff, state_in;
   operand_type modulus_ff, modulus_in;
   operand_type sq_ff, sq_in;
   operand_type acc_ff, acc_in;
   operand_type exp_ff, exp_in;
   count_type   bit_cnt_ff, bit_cnt_in;
   operand_type res_ff, res_in;
   logic        err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   operand_type rsp_data_ff, rsp_data_in;
   logic        rsp_err_ff, rsp_err_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic        req_take;
   logic        mod_zero;
   operand_type req_base;
   operand_type req_exp;

   assign req_base   = req_tdata[OP_W-1:0];
   assign req_exp    = req_tdata[REQ_DATA_W-1:OP_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign mod_zero   = (modulus_ff == '0);

   modexp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // operand selection for the multiplier
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.x     = sq_ff;
      mul_req.y     = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            // base times one reduces the base
            mul_req.start = req_take && !mod_zero;
            mul_req.x     = req_base;
            mul_req.y     = OP_W'(1);
         end
         ST_STEP: begin
            mul_req.start = 1'b1;
            mul_req.x     = exp_ff[0] ? acc_ff : sq_ff;
         end
         ST_MUL_ACC: begin
            mul_req.start = mul_rsp.done;
         end
         default: begin
            mul_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      if (csr_wr_en) begin
         modulus_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               exp_in     = req_exp;
               bit_cnt_in = CNT_W'(OP_W - 1);
               // one mod m is zero only for a modulus of one
               acc_in     = (modulus_ff == OP_W'(1)) ? '0 : OP_W'(1);
               if (mod_zero) begin
                  res_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = exp_ff[0] ? ST_MUL_ACC : ST_MUL_SQ;
         end
         ST_MUL_ACC: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.product;
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (mul_rsp.done) begin
               sq_in  = mul_rsp.product;
               exp_in = {1'b0, exp_ff[OP_W-1:1]};
               if (bit_cnt_ff == '0) begin
                  res_in   = acc_ff;
                  state_in = ST_FINISH;
               end else begin
                  bit_cnt_in = bit_cnt_ff - 1'b1;
                  state_in   = ST_STEP;
               end
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= OP_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      bit_cnt_ff  <= bit_cnt_in;
      res_ff      <= res_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ----- rtl/modexp_checker.sv -----
// ----------------------------------------------------------------------------
// modexp port checker
// watches the ports of the modular exponentiation block over time
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modexp_port_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  csr_wr_en,
   input logic [modexp_pkg::OP_W-1:0]           csr_wr_data,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [modexp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [modexp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                  rsp_tuser
);
   import modexp_pkg::*;

   operand_type           shadow_mod_ff;
   logic                  rsp_wait;
   logic                  rsp_err;
   logic                  rsp_ok;
   logic [RSP_DATA_W:0]   rsp_word;

   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign rsp_err  = rsp_tvalid && rsp_tuser;
   assign rsp_ok   = rsp_tvalid && !rsp_tuser;
   assign rsp_word = {rsp_tuser, rsp_tdata};

   // modulus as seen on the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_mod_ff <= OP_W'(1);
      end else if (csr_wr_en) begin
         shadow_mod_ff <= csr_wr_data;
      end
   end

   `MODEXP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_word))
   `MODEXP_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `MODEXP_ASSERT_NOW(a_err_zero, clock, reset, rsp_err, rsp_tdata == '0 && shadow_mod_ff == '0)
   `MODEXP_ASSERT_NOW(a_residue_range, clock, reset, rsp_ok, rsp_tdata < shadow_mod_ff)

endmodule

bind modular_exponentiation modexp_port_checker u_modexp_checker (
   .clock       (clock),
   .reset       (reset),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tdata   (req_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser)
);

// ----- bench/modexp_checker.sv -----
// ----------------------------------------------------------------------------
// modular exponentiation checker
// watches the request, response and csr ports, works out each residue by
// square and multiply at double width and compares it with the response
// ----------------------------------------------------------------------------
module modexp_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  modexp_pkg::operand_type           csr_wr_data,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [modexp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [modexp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                              rsp_tuser,
   output int                                fail_count,
   output int                                pending_count
);
   import modexp_pkg::*;

   localparam int REPORT_LINES = 40;

   typedef struct packed {
      logic        modulus_error;
      operand_type residue;
   } power_result_type;

   power_result_type expected_powers[$];
   operand_type      modulus_copy;

   function automatic power_result_type power_residue(operand_type base_value,
                                                      operand_type exponent,
                                                      operand_type modulus);
      power_result_type  result;
      logic [2*OP_W-1:0] square;
      logic [2*OP_W-1:0] acc;
      result = '0;
      if (modulus == '0) begin
         result.modulus_error = 1'b1;
         return result;
      end
      square = base_value % modulus;
      // 1 mod 1 is 0, so the accumulator starts reduced too
      acc = 64'd1 % modulus;
      for (int i = 0; i < OP_W; i++) begin
         if (exponent[i]) begin
            acc = (acc * square) % modulus;
         end
         square = (square * square) % modulus;
      end
      result.residue = acc[OP_W-1:0];
      return result;
   endfunction

   task automatic report_mismatch(string what, logic [OP_W-1:0] got,
                                  logic [OP_W-1:0] wanted);
      fail_count++;
      if (fail_count <= REPORT_LINES) begin
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, wanted);
      end
   endtask

   always @(posedge clock) begin
      power_result_type wanted;
      if (reset) begin
         expected_powers.delete();
         modulus_copy = 32'd1;
      end else begin
         if (csr_wr_en) begin
            modulus_copy = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_powers.size() == 0) begin
               report_mismatch("response with no request outstanding, residue",
                               rsp_tdata, '0);
            end else begin
               wanted = expected_powers.pop_front();
               if (rsp_tdata !== wanted.residue) begin
                  report_mismatch("residue", rsp_tdata, wanted.residue);
               end
               if (rsp_tuser !== wanted.modulus_error) begin
                  report_mismatch("modulus_error", {31'd0, rsp_tuser},
                                  {31'd0, wanted.modulus_error});
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_powers.push_back(power_residue(req_tdata[OP_W-1:0],
                                                    req_tdata[2*OP_W-1:OP_W],
                                                    modulus_copy));
         end
      end
      pending_count = expected_powers.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// modular exponentiation testbench
// directed corner requests under several moduli, then random phases with
// fresh moduli, random idling on both sides and one long response hold-off
// ----------------------------------------------------------------------------
module tb_top;
   import modexp_pkg::*;

   localparam int LONG_HOLD       = 7000;
   localparam int WATCHDOG_LIMIT  = 30000;
   localparam int SETTLE_CYCLES   = 2500;
   localparam int RANDOM_PHASES   = 9;
   localparam int PHASE_REQUESTS  = 30;
   localparam operand_type PRIMES [5] = '{32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'd65537,
                                          32'd1000000007, 32'd97};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   operand_type           csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int fail_count;
   int pending_count;
   bit quiet      = 1'b0;
   bit hold_armed = 1'b0;
   int idle_cycles;

   always #5 clock = ~clock;

   modular_exponentiation DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   modexp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer_request(operand_type base_value, operand_type exponent);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {exponent, base_value};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
   endtask

   // the block must be idle for a modulus change
   task automatic write_modulus(operand_type modulus);
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= modulus;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            stall_left = LONG_HOLD;
            hold_armed = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("modular_exponentiation test failed");
      $finish;
   end

   initial begin : stimulus
      operand_type modulus;
      operand_type base_value;
      operand_type exponent;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // modulus one out of reset: every residue is zero
      offer_request(32'd5, 32'd0);
      offer_request(32'd0, 32'd0);
      offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // zero modulus flags the error
      write_modulus(32'd0);
      offer_request(32'd7, 32'd3);
      offer_request(32'hFFFF_FFFF, 32'd0);

      write_modulus(32'hFFFF_FFFF);
      offer_request(32'd0, 32'd0);
      offer_request(32'd0, 32'd5);
      offer_request(32'hFFFF_FFFF, 32'd1);
      offer_request(32'hFFFF_FFFE, 32'd2);
      offer_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      offer_request(32'd2, 32'd31);
      offer_request(32'd3, 32'h8000_0000);
      offer_request(32'd1, 32'hFFFF_FFFF);

      // largest 32-bit prime: base equal to and above the modulus, fermat case
      write_modulus(32'hFFFF_FFFB);
      offer_request(32'hFFFF_FFFB, 32'd7);
      offer_request(32'hFFFF_FFFC, 32'd3);
      offer_request(32'd2, 32'hFFFF_FFFA);
      offer_request(32'd123456789, 32'd0);
      offer_request(32'hDEAD_BEEF, 32'hFFFF_FFFF);

      write_modulus(32'd2);
      offer_request(32'd3, 32'd1);
      offer_request(32'd2, 32'd5);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: modulus = $urandom();
            3:       modulus = $urandom_range(1, 16);
            4, 5:    modulus = PRIMES[$urandom_range(0, 4)];
            6:       modulus = 32'hFFFF_FFFF;
            7:       modulus = 32'h8000_0000;
            8:       modulus = $urandom() & 32'hFFFF_0000;
            default: modulus = '0;
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            quiet = 1'b1;
         end
         write_modulus(modulus);
         // first random phase: hold responses off so the block backs up
         if (phase == 0) begin
            hold_armed = 1'b1;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            case ($urandom_range(0, 4))
               0, 1:    base_value = $urandom();
               2:       base_value = $urandom_range(0, 8);
               3:       base_value = modulus - $urandom_range(0, 2);
               default: base_value = modulus + $urandom_range(0, 3);
            endcase
            case ($urandom_range(0, 5))
               0, 1, 2: exponent = $urandom();
               3:       exponent = $urandom_range(0, 64);
               4:       exponent = 32'd1 << $urandom_range(0, 31);
               default: exponent = 32'hFFFF_FFFF - $urandom_range(0, 3);
            endcase
            offer_request(base_value, exponent);
         end
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("modular_exponentiation test passed");
      end else begin
         $display("modular_exponentiation test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_mul.sv
rtl/modular_exponentiation.sv
rtl/modexp_checker.sv
bench/modexp_checker.sv
bench/tb_top.sv
